// ===== hdl/dtq_pkg.sv =====
// shared types and constants for the deadline timer queue
`default_nettype none
package dtq_pkg;

  localparam int NUM_TIMERS = 8;
  localparam int ID_W       = 3;
  localparam int CNT_W      = 4;
  localparam int PROD_W     = 46;

  localparam logic [63:0] MAX_DEADLINE = 64'h7fff_ffff_ffff_ffff;
  localparam logic [13:0] TICKS_PER_MS = 14'd10000;

  localparam logic [2:0] MODE_SET     = 3'd0;
  localparam logic [2:0] MODE_CANCEL  = 3'd1;
  localparam logic [2:0] MODE_CHECK   = 3'd2;
  localparam logic [2:0] MODE_SATISFY = 3'd3;
  localparam logic [2:0] MODE_QUERY   = 3'd4;

  localparam logic [1:0] KIND_ACK     = 2'd0;
  localparam logic [1:0] KIND_FIRED   = 2'd1;
  localparam logic [1:0] KIND_SUMMARY = 2'd2;
  localparam logic [1:0] KIND_QUERY   = 2'd3;

  typedef struct packed {
    logic [2:0]         mode;
    logic [2:0]         timer_id;
    logic [62:0]        now;
    logic signed [63:0] due_time;
    logic [31:0]        period_ms;
  } in_item_t;

  typedef struct packed {
    logic [1:0]         kind;
    logic [2:0]         slot;
    logic               flag;
    logic signed [63:0] remaining;
    logic               any_armed;
    logic               last;
  } out_item_t;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_SET_BEGIN,
    CMD_CANCEL,
    CMD_SAT_BEGIN,
    CMD_SAT_ADD,
    CMD_WALK_STEP,
    CMD_INSERT,
    CMD_EMIT_ACK,
    CMD_QUERY_EMIT,
    CMD_CHECK_BEGIN,
    CMD_CHECK_STEP
  } dp_cmd_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       due_zero;
    logic       has_period;
    logic       walk_done;
    logic       check_final;
    logic       out_free;
  } dp_status_t;

endpackage
`default_nettype wire

// ===== hdl/dtq_datapath.sv =====
// timer state, sorted queue, arithmetic and output register
`default_nettype none
module dtq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  dtq_pkg::dp_cmd_t    cmd,
  output dtq_pkg::dp_status_t status,
  input  logic                cfg_wr_en,
  input  logic [7:0]          cfg_wr_data,
  input  dtq_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_ready,
  output dtq_pkg::out_item_t  out_item
);
  import dtq_pkg::*;

  in_item_t                  item;
  logic [7:0]                sync_mask;
  logic [63:0]               deadline [NUM_TIMERS];
  logic [31:0]               period   [NUM_TIMERS];
  logic [ID_W-1:0]           order    [NUM_TIMERS];
  logic [NUM_TIMERS-1:0]     armed;
  logic [NUM_TIMERS-1:0]     expired;
  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          pos;
  logic [63:0]               dnew;
  logic [PROD_W-1:0]         prod;
  logic                      prev;
  logic                      any_reg;

  logic [ID_W-1:0]           id;
  logic [ID_W-1:0]           head;
  logic [ID_W-1:0]           unq_tgt;
  logic [ID_W-1:0]           unq_order [NUM_TIMERS];
  logic [CNT_W-1:0]          unq_cnt;
  logic [ID_W-1:0]           ins_order [NUM_TIMERS];
  logic [ID_W-1:0]           rd_idx;
  logic [63:0]               rd_dl;
  logic [63:0]               now_ext;
  logic [63:0]               addend;
  logic [63:0]               rel_sum;
  logic [63:0]               sat_dl;
  logic [63:0]               set_dl;
  logic                      head_due;
  logic                      walk_le;
  logic                      emit_cmd;

  assign id      = item.timer_id;
  assign head    = order[0];
  assign now_ext = {1'b0, item.now};

  always_comb begin
    case (item.mode)
      MODE_CHECK: rd_idx = head;
      MODE_QUERY: rd_idx = id;
      default:    rd_idx = order[pos[ID_W-1:0]];
    endcase
  end
  assign rd_dl = deadline[rd_idx];

  assign unq_tgt = (item.mode == MODE_CHECK) ? head : id;

  always_comb begin
    logic seen;
    seen = 1'b0;
    for (int q = 0; q < NUM_TIMERS; q++) begin
      if (armed[unq_tgt] && (CNT_W'(q) < count) && (order[q] == unq_tgt)) begin
        seen = 1'b1;
      end
      if (seen && (q < NUM_TIMERS - 1)) begin
        unq_order[q] = order[q+1];
      end else begin
        unq_order[q] = order[q];
      end
    end
    unq_cnt = count - CNT_W'(seen);
  end

  always_comb begin
    for (int q = 0; q < NUM_TIMERS; q++) begin
      if ((q > 0) && (CNT_W'(q) > pos)) begin
        ins_order[q] = order[q-1];
      end else if (CNT_W'(q) == pos) begin
        ins_order[q] = id;
      end else begin
        ins_order[q] = order[q];
      end
    end
  end

  // relative deadline with saturation
  assign addend  = (cmd == CMD_SAT_ADD) ? {{(64-PROD_W){1'b0}}, prod}
                                        : 64'(~item.due_time + 64'sd1);
  assign rel_sum = now_ext + addend;
  assign sat_dl  = rel_sum[63] ? MAX_DEADLINE : rel_sum;
  assign set_dl  = item.due_time[63] ? sat_dl : 64'(item.due_time);

  assign head_due = (count != '0) && (rd_dl <= now_ext);
  assign walk_le  = (pos < count) && (rd_dl <= dnew);

  assign emit_cmd = (cmd == CMD_EMIT_ACK) || (cmd == CMD_QUERY_EMIT) ||
                    (cmd == CMD_CHECK_STEP);

  assign status.mode        = item.mode;
  assign status.due_zero    = (item.due_time == 64'sd0);
  assign status.has_period  = (period[id] != 32'd0);
  assign status.walk_done   = !walk_le;
  assign status.check_final = !head_due;
  assign status.out_free    = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_mask <= '0;
      armed     <= '0;
      expired   <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        deadline[i] <= '0;
        period[i]   <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        sync_mask <= cfg_wr_data;
      end
      if (out_valid && out_ready && !emit_cmd) begin
        out_valid <= 1'b0;
      end
      case (cmd)
        CMD_LOAD: begin
          item <= in_item;
        end
        CMD_SET_BEGIN: begin
          prev       <= expired[id];
          period[id] <= item.period_ms;
          pos        <= '0;
          order      <= unq_order;
          count      <= unq_cnt;
          armed[id]  <= 1'b0;
          if (item.due_time == 64'sd0) begin
            expired[id] <= 1'b1;
          end else begin
            expired[id]  <= 1'b0;
            dnew         <= set_dl;
            deadline[id] <= set_dl;
          end
        end
        CMD_CANCEL: begin
          prev         <= expired[id];
          order        <= unq_order;
          count        <= unq_cnt;
          armed[id]    <= 1'b0;
          deadline[id] <= '0;
          expired[id]  <= 1'b0;
        end
        CMD_SAT_BEGIN: begin
          prev <= expired[id];
          if (sync_mask[id]) begin
            expired[id] <= 1'b0;
          end
          prod <= PROD_W'(period[id]) * PROD_W'(TICKS_PER_MS);
        end
        CMD_SAT_ADD: begin
          dnew         <= sat_dl;
          deadline[id] <= sat_dl;
          order        <= unq_order;
          count        <= unq_cnt;
          armed[id]    <= 1'b0;
          pos          <= '0;
        end
        CMD_WALK_STEP: begin
          pos <= pos + CNT_W'(1);
        end
        CMD_INSERT: begin
          order     <= ins_order;
          count     <= count + CNT_W'(1);
          armed[id] <= 1'b1;
        end
        CMD_EMIT_ACK: begin
          out_valid <= 1'b1;
          out_item  <= '{kind: KIND_ACK, slot: id, flag: prev, remaining: 64'sd0,
                         any_armed: 1'b0, last: 1'b1};
        end
        CMD_QUERY_EMIT: begin
          out_valid <= 1'b1;
          out_item  <= '{kind: KIND_QUERY, slot: id, flag: expired[id],
                         remaining: $signed(rd_dl - now_ext),
                         any_armed: 1'b0, last: 1'b1};
        end
        CMD_CHECK_BEGIN: begin
          any_reg <= (count != '0);
        end
        CMD_CHECK_STEP: begin
          out_valid <= 1'b1;
          if (head_due) begin
            order         <= unq_order;
            count         <= unq_cnt;
            armed[head]   <= 1'b0;
            expired[head] <= 1'b1;
            out_item <= '{kind: KIND_FIRED, slot: head, flag: 1'b0, remaining: 64'sd0,
                          any_armed: 1'b0, last: 1'b0};
          end else if (count != '0) begin
            out_item <= '{kind: KIND_SUMMARY, slot: head, flag: 1'b0,
                          remaining: $signed(rd_dl - now_ext),
                          any_armed: any_reg, last: 1'b1};
          end else begin
            out_item <= '{kind: KIND_SUMMARY, slot: '0, flag: 1'b0, remaining: 64'sd0,
                          any_armed: any_reg, last: 1'b1};
          end
        end
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(NUM_TIMERS)) else $error("queue count out of range");
  a_count_armed: assert property (@(posedge clk) disable iff (rst)
    $countones(armed) == int'(count)) else $error("armed bits disagree with count");
  a_fire_not_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && (out_item.kind == KIND_FIRED) |-> !out_item.last)
    else $error("fired item marked last");
`endif

endmodule
`default_nettype wire

// ===== hdl/dtq_ctrl.sv =====
// command sequencer for the deadline timer queue
`default_nettype none
module dtq_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  dtq_pkg::dp_status_t status,
  output dtq_pkg::dp_cmd_t    cmd
);
  import dtq_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE, ST_EXEC, ST_SAT2, ST_WALK, ST_ACK, ST_QUERY, ST_CHECK
  } state_t;

  state_t state, state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = CMD_NONE;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd        = CMD_LOAD;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (status.mode)
          MODE_SET: begin
            cmd        = CMD_SET_BEGIN;
            state_next = status.due_zero ? ST_ACK : ST_WALK;
          end
          MODE_CANCEL: begin
            cmd        = CMD_CANCEL;
            state_next = ST_ACK;
          end
          MODE_CHECK: begin
            cmd        = CMD_CHECK_BEGIN;
            state_next = ST_CHECK;
          end
          MODE_SATISFY: begin
            cmd        = CMD_SAT_BEGIN;
            state_next = ST_SAT2;
          end
          MODE_QUERY: begin
            state_next = ST_QUERY;
          end
          default: begin
            state_next = ST_IDLE;
          end
        endcase
      end
      ST_SAT2: begin
        if (status.has_period) begin
          cmd        = CMD_SAT_ADD;
          state_next = ST_WALK;
        end else begin
          state_next = ST_ACK;
        end
      end
      ST_WALK: begin
        if (status.walk_done) begin
          cmd        = CMD_INSERT;
          state_next = ST_ACK;
        end else begin
          cmd = CMD_WALK_STEP;
        end
      end
      ST_ACK: begin
        if (status.out_free) begin
          cmd        = CMD_EMIT_ACK;
          state_next = ST_IDLE;
        end
      end
      ST_QUERY: begin
        if (status.out_free) begin
          cmd        = CMD_QUERY_EMIT;
          state_next = ST_IDLE;
        end
      end
      ST_CHECK: begin
        if (status.out_free) begin
          cmd = CMD_CHECK_STEP;
          if (status.check_final) begin
            state_next = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/deadline_timer_queue_unit.sv =====
// top level of the deadline timer queue
`default_nettype none
// Eight timers with deadlines held in a queue sorted by deadline. One item is
// handled at a time: cancel, query and a set with zero due time go straight to
// their result; a set and a re-arming satisfy first walk the queue entry by entry
// to find the insert point; a satisfy that does not re-arm skips the walk; check
// emits one fired result per due timer and then a summary. The queue walk does
// one 64-bit compare a cycle; a result waiting in the output register stalls
// only the next emitting step.
module deadline_timer_queue_unit (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [7:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  dtq_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_ready,
  output dtq_pkg::out_item_t out_item
);
  import dtq_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  dtq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  dtq_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item)
  );

endmodule
`default_nettype wire

// ===== test/dtq_checker.sv =====
// checker for the deadline timer queue: timer model, expected result queue and compare
`timescale 1ns / 100ps
`default_nettype none
module dtq_checker (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr_en,
  input  wire logic [7:0]         cfg_wr_data,
  input  wire logic               in_valid,
  input  wire logic               in_ready,
  input  wire dtq_pkg::in_item_t  in_item,
  input  wire logic               out_valid,
  input  wire logic               out_ready,
  input  wire dtq_pkg::out_item_t out_item,
  output int                      fail_count,
  output int                      pending,
  output int                      results_seen
);
  import dtq_pkg::*;

  logic [7:0]  sync_mask;
  logic [63:0] dl [NUM_TIMERS];
  logic        armed [NUM_TIMERS];
  logic        expired [NUM_TIMERS];
  logic [31:0] period [NUM_TIMERS];
  int          order [$];
  out_item_t   expected_results [$];

  function automatic logic [63:0] sat_add(logic [62:0] now, logic [63:0] delay);
    logic [64:0] s;
    s = {2'b0, now} + {1'b0, delay};
    return (s > {1'b0, MAX_DEADLINE}) ? MAX_DEADLINE : s[63:0];
  endfunction

  function automatic void drop_timer(int id);
    if (!armed[id]) return;
    foreach (order[p]) if (order[p] == id) begin
      order.delete(p);
      break;
    end
    armed[id] = 1'b0;
  endfunction

  function automatic void arm_timer(int id);
    int p;
    drop_timer(id);
    p = 0;
    while (p < order.size() && dl[order[p]] <= dl[id]) p++;
    order.insert(p, id);
    armed[id] = 1'b1;
  endfunction

  function automatic void push_result(logic [1:0] k, int s, logic f, logic [63:0] r,
                                      logic a, logic l);
    out_item_t o;
    o.kind = k; o.slot = s[2:0]; o.flag = f; o.remaining = r;
    o.any_armed = a; o.last = l;
    expected_results.push_back(o);
  endfunction

  function automatic void predict_timers(in_item_t it);
    int id, h;
    logic prev;
    id = it.timer_id;
    if (it.mode == MODE_CHECK) begin
      if (order.size() == 0) begin
        push_result(KIND_SUMMARY, 0, 0, 0, 0, 1);
        return;
      end
      while (order.size() > 0 && dl[order[0]] <= {1'b0, it.now}) begin
        h = order[0];
        drop_timer(h);
        expired[h] = 1'b1;
        push_result(KIND_FIRED, h, 0, 0, 0, 0);
      end
      if (order.size() > 0)
        push_result(KIND_SUMMARY, order[0], 0, dl[order[0]] - {1'b0, it.now}, 1, 1);
      else
        push_result(KIND_SUMMARY, 0, 0, 0, 1, 1);
      return;
    end
    if (it.mode > MODE_QUERY) return;
    prev = expired[id];
    case (it.mode)
      MODE_SET: begin
        period[id] = it.period_ms;
        if (it.due_time == 0) begin
          drop_timer(id);
          expired[id] = 1'b1;
        end else begin
          expired[id] = 1'b0;
          dl[id] = it.due_time[63] ? sat_add(it.now, -it.due_time) : it.due_time;
          arm_timer(id);
        end
        push_result(KIND_ACK, id, prev, 0, 0, 1);
      end
      MODE_CANCEL: begin
        drop_timer(id);
        dl[id] = 0;
        expired[id] = 1'b0;
        push_result(KIND_ACK, id, prev, 0, 0, 1);
      end
      MODE_SATISFY: begin
        if (sync_mask[id]) expired[id] = 1'b0;
        if (period[id] != 0) begin
          dl[id] = sat_add(it.now, 64'(period[id]) * 64'(TICKS_PER_MS));
          arm_timer(id);
        end
        push_result(KIND_ACK, id, prev, 0, 0, 1);
      end
      default: push_result(KIND_QUERY, id, prev, dl[id] - {1'b0, it.now}, 0, 1);
    endcase
  endfunction

  always @(posedge clk) begin
    out_item_t e;
    if (rst) begin
      sync_mask <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        dl[i] = 0; armed[i] = 0; expired[i] = 0; period[i] = 0;
      end
      order.delete();
      expected_results.delete();
      fail_count <= 0;
      results_seen <= 0;
    end else begin
      if (cfg_wr_en) sync_mask <= cfg_wr_data;
      if (out_valid && out_ready) begin
        results_seen <= results_seen + 1;
        if (expected_results.size() == 0) begin
          if (fail_count < 10) $display("unexpected result %p", out_item);
          fail_count <= fail_count + 1;
        end else begin
          e = expected_results.pop_front();
          if (out_item !== e) begin
            if (fail_count < 10) $display("mismatch: expected %p got %p", e, out_item);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_valid && in_ready) predict_timers(in_item);
    end
    pending <= expected_results.size();
  end
endmodule
`default_nettype wire

// ===== test/tb_deadline_timer_queue_unit.sv =====
// testbench top for the deadline timer queue: stimulus, handshakes and verdict
`timescale 1ns / 100ps
`default_nettype none
module tb_deadline_timer_queue_unit;
  import dtq_pkg::*;

  logic      clk = 0, rst = 1;
  logic      cfg_wr_en = 0;
  logic [7:0] cfg_wr_data = 0;
  logic      in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_item_t  in_item = '0;
  out_item_t out_item;
  int        fail_count, pending, results_seen;
  int        hold_off = 0;
  int        items_sent = 0;
  logic [62:0] clock_now = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  deadline_timer_queue_unit dut (.*);
  dtq_checker chk (.*);

  // receiver stalls, with a long hold-off when requested
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_ready <= 1'b0;
    end else if (items_sent % 100 < 40) out_ready <= 1'b1;
    else out_ready <= ($urandom_range(0, 3) != 0);
  end

  task automatic send_item(in_item_t it);
    in_valid <= 1'b1;
    in_item <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if ($urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic send_cmd(logic [2:0] m, logic [2:0] id, logic [62:0] n,
                          logic [63:0] due, logic [31:0] per);
    in_item_t it;
    it.mode = m; it.timer_id = id; it.now = n; it.due_time = due; it.period_ms = per;
    send_item(it);
  endtask

  task automatic write_mask(logic [7:0] v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_due(logic [62:0] n);
    case ($urandom_range(0, 5))
      0: return 0;
      1: return -64'($urandom_range(0, 200000));
      2: return {1'b0, n} + $urandom_range(1, 300000);
      3: return rand64();
      4: return {1'b0, n} - $urandom_range(0, 1000);
      default: return 64'h8000_0000_0000_0000 | rand64();
    endcase
  endfunction

  initial begin
    in_item_t it;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    write_mask(8'h00);
    // directed
    send_cmd(MODE_CHECK, 0, 0, 0, 0);
    send_cmd(MODE_QUERY, 7, 63'h7fff_ffff_ffff_ffff, 0, 0);
    send_cmd(MODE_SET, 0, 100, 500, 0);
    send_cmd(MODE_SET, 1, 100, 500, 32'hffff_ffff);
    send_cmd(MODE_SET, 2, 63'h7fff_ffff_ffff_fff0, 64'h8000_0000_0000_0000, 1);
    send_cmd(MODE_SET, 3, 10, 0, 5);
    send_cmd(MODE_SET, 4, 10, 64'h7fff_ffff_ffff_ffff, 0);
    send_cmd(MODE_SET, 5, 10, -64'd20, 0);
    send_cmd(MODE_QUERY, 5, 10, 0, 0);
    send_cmd(MODE_CHECK, 0, 600, 0, 0);
    send_cmd(MODE_SATISFY, 1, 63'h7fff_ffff_ffff_0000, 0, 0);
    send_cmd(MODE_SATISFY, 0, 600, 0, 0);
    send_cmd(MODE_CANCEL, 3, 600, 0, 0);
    send_cmd(MODE_CANCEL, 6, 600, 0, 0);
    send_cmd(3'd5, 2, 0, 0, 0);
    send_cmd(3'd7, 2, 0, 0, 0);
    send_cmd(MODE_CHECK, 5, 63'h7fff_ffff_ffff_ffff, 0, 0);
    send_cmd(MODE_CHECK, 0, 0, 0, 0);
    write_mask(8'hff);
    for (int i = 0; i < 8; i++) send_cmd(MODE_SET, 3'(i), 0, 1000, 0);
    send_cmd(MODE_CHECK, 0, 2000, 0, 0);
    hold_off = 400;
    for (int i = 0; i < 8; i++) send_cmd(MODE_SATISFY, 3'(i), 0, 0, 0);
    // random
    for (int ph = 0; ph < 3; ph++) begin
      write_mask(ph == 0 ? 8'h5a : 8'($urandom_range(0, 255)));
      for (int k = 0; k < 72; k++) begin
        clock_now = clock_now + $urandom_range(0, 40000);
        if ($urandom_range(0, 30) == 0) clock_now = 63'({$urandom, $urandom});
        it.now = clock_now;
        it.timer_id = 3'($urandom_range(0, 7));
        it.mode = ($urandom_range(0, 40) == 0) ? 3'($urandom_range(5, 7))
                                               : 3'($urandom_range(0, 4));
        it.due_time = pick_due(clock_now);
        it.period_ms = ($urandom_range(0, 2) == 0) ? 0 :
                       ($urandom_range(0, 5) == 0) ? $urandom : $urandom_range(1, 5);
        if ($urandom_range(0, 20) == 0) it.now = 63'({$urandom, $urandom});
        send_item(it);
      end
    end
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("covered %0d input items and %0d results over several mask settings",
             items_sent, results_seen);
    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

  initial begin
    #4000000;
    $display("Regression FAIL");
    $finish;
  end
endmodule
`default_nettype wire
